>>> hw/rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the 1-Wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  // tick counter width and its saturation value
  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // tick register width and the config port
  localparam int REG_W = 10;
  localparam int NUM_REGS = 8;
  localparam int IDX_W = 3;

  localparam int BITS_W = 4;
  localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;

  // register indexes
  localparam logic [IDX_W-1:0] REG_RESET_LOW      = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESENCE_WAIT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_RESET_RECOVERY = 3'd2;
  localparam logic [IDX_W-1:0] REG_SHORT          = 3'd3;
  localparam logic [IDX_W-1:0] REG_LONG           = 3'd4;
  localparam logic [IDX_W-1:0] REG_READ_LOW       = 3'd5;
  localparam logic [IDX_W-1:0] REG_READ_SAMPLE    = 3'd6;
  localparam logic [IDX_W-1:0] REG_READ_TAIL      = 3'd7;

  // reset values of the tick registers
  localparam logic [REG_W-1:0] RST_RESET_LOW      = 10'd500;
  localparam logic [REG_W-1:0] RST_PRESENCE_WAIT  = 10'd30;
  localparam logic [REG_W-1:0] RST_RESET_RECOVERY = 10'd400;
  localparam logic [REG_W-1:0] RST_SHORT          = 10'd5;
  localparam logic [REG_W-1:0] RST_LONG           = 10'd55;
  localparam logic [REG_W-1:0] RST_READ_LOW       = 10'd2;
  localparam logic [REG_W-1:0] RST_READ_SAMPLE    = 10'd7;
  localparam logic [REG_W-1:0] RST_READ_TAIL      = 10'd50;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_RESET = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_RST_LOW  = 9'b000000010,
    PH_RST_WAIT = 9'b000000100,
    PH_RST_REC  = 9'b000001000,
    PH_WR_LOW   = 9'b000010000,
    PH_WR_HIGH  = 9'b000100000,
    PH_RD_LOW   = 9'b001000000,
    PH_RD_WAIT  = 9'b010000000,
    PH_RD_TAIL  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] reset_low;
    logic [REG_W-1:0] presence_wait;
    logic [REG_W-1:0] reset_recovery;
    logic [REG_W-1:0] short_t;
    logic [REG_W-1:0] long_t;
    logic [REG_W-1:0] read_low;
    logic [REG_W-1:0] read_sample;
    logic [REG_W-1:0] read_tail;
  } cfg_t;

  // query from the sequencer to the timing registers
  typedef struct packed {
    phase_t phase;
    logic   bit0;
  } len_req_t;

  typedef struct packed {
    phase_t            phase;
    logic [CNT_W-1:0]  tick_count;
    logic [7:0]        shift_byte;
    logic [BITS_W-1:0] bits_left;
    logic              presence_flag;
    logic [7:0]        read_byte;
  } seq_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] write_data;
    logic       line_in;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/owbm_if.sv
// ----------------------------------------------------------------------------
// owbm_in_if / owbm_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface owbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] write_data;
  logic       line_in;

  modport source (output valid, action, write_data, line_in, input ready);
  modport sink   (input valid, action, write_data, line_in, output ready);
endinterface

interface owbm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;
  logic       rejected;

  modport source (output valid, drive_low, busy_res, done_res, presence, read_data,
                  rejected, input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, read_data,
                  rejected, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/owbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owbm_cfg_regs
// Tick registers and the phase length lookup with clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_cfg_regs
  import owbm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data,
  input  wire len_req_t         len_req,
  output logic [CNT_W-1:0]      phase_len
);

  cfg_t cfg_r;
  logic [REG_W-1:0] raw_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low      <= RST_RESET_LOW;
      cfg_r.presence_wait  <= RST_PRESENCE_WAIT;
      cfg_r.reset_recovery <= RST_RESET_RECOVERY;
      cfg_r.short_t        <= RST_SHORT;
      cfg_r.long_t         <= RST_LONG;
      cfg_r.read_low       <= RST_READ_LOW;
      cfg_r.read_sample    <= RST_READ_SAMPLE;
      cfg_r.read_tail      <= RST_READ_TAIL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:      cfg_r.reset_low      <= cfg_data;
        REG_PRESENCE_WAIT:  cfg_r.presence_wait  <= cfg_data;
        REG_RESET_RECOVERY: cfg_r.reset_recovery <= cfg_data;
        REG_SHORT:          cfg_r.short_t        <= cfg_data;
        REG_LONG:           cfg_r.long_t         <= cfg_data;
        REG_READ_LOW:       cfg_r.read_low       <= cfg_data;
        REG_READ_SAMPLE:    cfg_r.read_sample    <= cfg_data;
        REG_READ_TAIL:      cfg_r.read_tail      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (len_req.phase)
      PH_RST_LOW:  raw_len = cfg_r.reset_low;
      PH_RST_WAIT: raw_len = cfg_r.presence_wait;
      PH_RST_REC:  raw_len = cfg_r.reset_recovery;
      PH_WR_LOW:   raw_len = len_req.bit0 ? cfg_r.short_t : cfg_r.long_t;
      PH_WR_HIGH:  raw_len = len_req.bit0 ? cfg_r.long_t : cfg_r.short_t;
      PH_RD_LOW:   raw_len = cfg_r.read_low;
      PH_RD_WAIT:  raw_len = cfg_r.read_sample;
      default:     raw_len = cfg_r.read_tail;
    endcase
    // zero behaves as one, values past the counter range saturate
    if (raw_len == '0) begin
      phase_len = CNT_W'(1);
    end else if (32'(raw_len) > 32'(CNT_MAX)) begin
      phase_len = CNT_MAX;
    end else begin
      phase_len = CNT_W'(raw_len);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/owbm_step.sv
// ----------------------------------------------------------------------------
// owbm_step
// Per-beat sequencer step: command start, tick count, phase advance, result.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_step
  import owbm_pkg::*;
(
  input  wire seq_state_t        cur,
  input  wire in_item_t          item,
  input  wire logic [CNT_W-1:0]  phase_len,
  output len_req_t               len_req,
  output seq_state_t             nxt,
  output res_t                   res
);

  seq_state_t       eff;
  logic             start;
  logic             rej;
  logic [CNT_W-1:0] tick_inc;
  logic             done;

  always_comb begin
    eff   = cur;
    start = (item.action != ACT_TICK) && (cur.phase == PH_IDLE);
    rej   = (item.action != ACT_TICK) && (cur.phase != PH_IDLE);
    if (start) begin
      eff.tick_count = '0;
      case (item.action)
        ACT_RESET: eff.phase = PH_RST_LOW;
        ACT_WRITE: begin
          eff.phase      = PH_WR_LOW;
          eff.shift_byte = item.write_data;
          eff.bits_left  = BITS_PER_BYTE;
        end
        default: begin
          eff.phase      = PH_RD_LOW;
          eff.shift_byte = '0;
          eff.bits_left  = BITS_PER_BYTE;
        end
      endcase
    end
  end

  assign len_req.phase = eff.phase;
  assign len_req.bit0  = eff.shift_byte[0];

  always_comb begin
    nxt      = eff;
    done     = 1'b0;
    tick_inc = (eff.tick_count < CNT_MAX) ? eff.tick_count + CNT_W'(1) : eff.tick_count;
    if (eff.phase != PH_IDLE) begin
      nxt.tick_count = tick_inc;
      if (tick_inc >= phase_len) begin
        nxt.tick_count = '0;
        case (eff.phase)
          PH_RST_LOW:  nxt.phase = PH_RST_WAIT;
          PH_RST_WAIT: begin
            nxt.presence_flag = ~item.line_in;
            nxt.phase         = PH_RST_REC;
          end
          PH_RST_REC: begin
            nxt.phase = PH_IDLE;
            done      = 1'b1;
          end
          PH_WR_LOW:   nxt.phase = PH_WR_HIGH;
          PH_WR_HIGH: begin
            nxt.shift_byte = {1'b0, eff.shift_byte[7:1]};
            if (eff.bits_left <= BITS_W'(1)) begin
              nxt.bits_left = '0;
              nxt.phase     = PH_IDLE;
              done          = 1'b1;
            end else begin
              nxt.bits_left = eff.bits_left - BITS_W'(1);
              nxt.phase     = PH_WR_LOW;
            end
          end
          PH_RD_LOW:   nxt.phase = PH_RD_WAIT;
          PH_RD_WAIT: begin
            nxt.shift_byte = {item.line_in, eff.shift_byte[7:1]};
            nxt.phase      = PH_RD_TAIL;
          end
          PH_RD_TAIL: begin
            if (eff.bits_left <= BITS_W'(1)) begin
              nxt.bits_left = '0;
              nxt.read_byte = eff.shift_byte;
              nxt.phase     = PH_IDLE;
              done          = 1'b1;
            end else begin
              nxt.bits_left = eff.bits_left - BITS_W'(1);
              nxt.phase     = PH_RD_LOW;
            end
          end
          default:     nxt.phase = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    res.busy_res  = (eff.phase != PH_IDLE);
    res.drive_low = (eff.phase == PH_RST_LOW) || (eff.phase == PH_WR_LOW) ||
                    (eff.phase == PH_RD_LOW);
    res.done_res  = done;
    res.presence  = nxt.presence_flag;
    res.read_data = nxt.read_byte;
    res.rejected  = rej;
  end

endmodule

`default_nettype wire

>>> hw/rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped by microsecond tick beats: reset/presence,
// byte write and byte read sequences, one result beat per command beat.
// ----------------------------------------------------------------------------
// an input beat passes the input reg, then the result reg, to its result beat
// throughput: 1 beat per cycle unless stalled; state steps once per beat
// a stalled result beat holds the result reg; an empty input reg takes a beat
// reset (rst_n low, synchronous): sequencer idle, counters and bytes zero,
// tick registers back to their default timings, both channels empty
`default_nettype none

module one_wire_bus_master
  import owbm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  owbm_in_if.sink               in_chan,
  owbm_out_if.source            out_chan,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data
);

  // input register
  logic       in_valid_r;
  in_item_t   in_item_r;

  // result register
  logic       out_valid_r;
  res_t       res_r;

  // sequencer state
  seq_state_t state_r;
  seq_state_t state_nxt;
  res_t       res_nxt;

  len_req_t         len_req;
  logic [CNT_W-1:0] phase_len;
  logic             step_en;

  // the held beat moves on when the result reg is free or being drained
  assign step_en       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.action     <= in_chan.action;
      in_item_r.write_data <= in_chan.write_data;
      in_item_r.line_in    <= in_chan.line_in;
    end
  end

  owbm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .len_req   (len_req),
    .phase_len (phase_len)
  );

  owbm_step u_step (
    .cur       (state_r),
    .item      (in_item_r),
    .phase_len (phase_len),
    .len_req   (len_req),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  // sequencer state advances once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_IDLE;
      state_r.tick_count    <= '0;
      state_r.shift_byte    <= '0;
      state_r.bits_left     <= '0;
      state_r.presence_flag <= 1'b0;
      state_r.read_byte     <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.drive_low = res_r.drive_low;
  assign out_chan.busy_res  = res_r.busy_res;
  assign out_chan.done_res  = res_r.done_res;
  assign out_chan.presence  = res_r.presence;
  assign out_chan.read_data = res_r.read_data;
  assign out_chan.rejected  = res_r.rejected;

  // a completing sequence was running on that beat
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.done_res) |-> res_r.busy_res)
    else $error("done without busy");

  // the line is only pulled low inside a sequence
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.drive_low) |-> res_r.busy_res)
    else $error("drive low while idle");

  // a command is only rejected while a sequence runs
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.rejected) |-> res_r.busy_res)
    else $error("reject while idle");

  // bit counter never exceeds one byte
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bits_left <= BITS_PER_BYTE)
    else $error("bit counter out of range");

endmodule

`default_nettype wire

>>> bench/owbm_bus_check.sv
// ----------------------------------------------------------------------------
// owbm_bus_check
// Watches the command, result and register ports of the 1-Wire master, runs
// its own copy of the bus sequencer on every accepted command beat and checks
// each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module owbm_bus_check
  import owbm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  owbm_in_if                    in_mon,
  owbm_out_if                   out_mon,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding,
  output logic                  seq_active
);

  localparam int PRINT_CAP = 100;

  // shadow copy of the tick registers and the sequencer
  logic [REG_W-1:0]  timing [NUM_REGS];
  phase_t            ph;
  logic [CNT_W-1:0]  ticks;
  logic [7:0]        shreg;
  logic [BITS_W-1:0] bits_left;
  logic              present;
  logic [7:0]        rx_byte;

  res_t     expected_q [$];
  in_item_t cmd_beat;
  res_t     want;
  res_t     got;

  initial begin
    errors      = 0;
    outstanding = 0;
    seq_active  = 1'b0;
  end

  // length of the running phase in ticks, zero counts as one
  function automatic int unsigned phase_ticks();
    logic [REG_W-1:0] r;
    int unsigned      n;
    case (ph)
      PH_RST_LOW:  r = timing[REG_RESET_LOW];
      PH_RST_WAIT: r = timing[REG_PRESENCE_WAIT];
      PH_RST_REC:  r = timing[REG_RESET_RECOVERY];
      PH_WR_LOW:   r = shreg[0] ? timing[REG_SHORT] : timing[REG_LONG];
      PH_WR_HIGH:  r = shreg[0] ? timing[REG_LONG] : timing[REG_SHORT];
      PH_RD_LOW:   r = timing[REG_READ_LOW];
      PH_RD_WAIT:  r = timing[REG_READ_SAMPLE];
      default:     r = timing[REG_READ_TAIL];
    endcase
    n = r;
    if (n == 0) n = 1;
    if (n > CNT_MAX) n = CNT_MAX;
    return n;
  endfunction

  // one microsecond of bus time
  function automatic res_t bus_step(in_item_t b);
    res_t r;
    r = '0;
    if (action_t'(b.action) != ACT_TICK) begin
      if (ph != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        ticks = '0;
        case (action_t'(b.action))
          ACT_RESET: ph = PH_RST_LOW;
          ACT_WRITE: begin
            ph        = PH_WR_LOW;
            shreg     = b.write_data;
            bits_left = BITS_PER_BYTE;
          end
          default: begin
            ph        = PH_RD_LOW;
            shreg     = '0;
            bits_left = BITS_PER_BYTE;
          end
        endcase
      end
    end
    if (ph != PH_IDLE) begin
      r.busy_res  = 1'b1;
      r.drive_low = (ph == PH_RST_LOW) || (ph == PH_WR_LOW) || (ph == PH_RD_LOW);
      if (ticks < CNT_MAX) ticks = ticks + 1'b1;
      if (ticks >= phase_ticks()) begin
        ticks = '0;
        case (ph)
          PH_RST_LOW: ph = PH_RST_WAIT;
          PH_RST_WAIT: begin
            present = ~b.line_in;
            ph      = PH_RST_REC;
          end
          PH_RST_REC: begin
            ph         = PH_IDLE;
            r.done_res = 1'b1;
          end
          PH_WR_LOW: ph = PH_WR_HIGH;
          PH_WR_HIGH: begin
            shreg = shreg >> 1;
            if (bits_left <= 1) begin
              bits_left  = '0;
              ph         = PH_IDLE;
              r.done_res = 1'b1;
            end else begin
              bits_left = bits_left - 1'b1;
              ph        = PH_WR_LOW;
            end
          end
          PH_RD_LOW: ph = PH_RD_WAIT;
          PH_RD_WAIT: begin
            shreg = {b.line_in, shreg[7:1]};
            ph    = PH_RD_TAIL;
          end
          PH_RD_TAIL: begin
            if (bits_left <= 1) begin
              bits_left  = '0;
              rx_byte    = shreg;
              ph         = PH_IDLE;
              r.done_res = 1'b1;
            end else begin
              bits_left = bits_left - 1'b1;
              ph        = PH_RD_LOW;
            end
          end
          default: ph = PH_IDLE;
        endcase
      end
    end
    r.presence  = present;
    r.read_data = rx_byte;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      if (errors <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      timing[REG_RESET_LOW]      = RST_RESET_LOW;
      timing[REG_PRESENCE_WAIT]  = RST_PRESENCE_WAIT;
      timing[REG_RESET_RECOVERY] = RST_RESET_RECOVERY;
      timing[REG_SHORT]          = RST_SHORT;
      timing[REG_LONG]           = RST_LONG;
      timing[REG_READ_LOW]       = RST_READ_LOW;
      timing[REG_READ_SAMPLE]    = RST_READ_SAMPLE;
      timing[REG_READ_TAIL]      = RST_READ_TAIL;
      ph        = PH_IDLE;
      ticks     = '0;
      shreg     = '0;
      bits_left = '0;
      present   = 1'b0;
      rx_byte   = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) timing[cfg_index] = cfg_data;
      if (in_mon.valid && in_mon.ready) begin
        cmd_beat.action     = in_mon.action;
        cmd_beat.write_data = in_mon.write_data;
        cmd_beat.line_in    = in_mon.line_in;
        expected_q.push_back(bus_step(cmd_beat));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.drive_low = out_mon.drive_low;
        got.busy_res  = out_mon.busy_res;
        got.done_res  = out_mon.done_res;
        got.presence  = out_mon.presence;
        got.read_data = out_mon.read_data;
        got.rejected  = out_mon.rejected;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: result beat with nothing expected, expected none, got %0h",
                     $time, got);
        end else begin
          want = expected_q.pop_front();
          check_field("drive_low", want.drive_low, got.drive_low);
          check_field("busy_res",  want.busy_res,  got.busy_res);
          check_field("done_res",  want.done_res,  got.done_res);
          check_field("presence",  want.presence,  got.presence);
          check_field("read_data", want.read_data, got.read_data);
          check_field("rejected",  want.rejected,  got.rejected);
        end
      end
    end
    outstanding <= expected_q.size();
    seq_active  <= (ph != PH_IDLE);
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for the 1-Wire bus master: default timings first, then directed
// reset/write/read sequences and random command streams under several tick
// register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import owbm_pkg::*;

  // cycles without any accepted beat or register write before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // long receiver hold-off used to back the block up
  localparam int HOLD_CYCLES = 64;

  logic clk;
  logic rst_n;

  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  logic seq_active;

  // idle percentages for the sender and receiver, changed per phase
  int snd_idle;
  int rcv_idle;

  int hold_left;
  int results_seen;
  int quiet_cycles;

  logic [REG_W-1:0] timings [NUM_REGS];

  owbm_in_if  in_chan ();
  owbm_out_if out_chan ();

  one_wire_bus_master uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  owbm_bus_check bus_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (mismatches),
    .outstanding (outstanding),
    .seq_active  (seq_active)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // build one command beat
  function automatic in_item_t beat(action_t a, logic [7:0] d, logic l);
    in_item_t b;
    b.action     = a;
    b.write_data = d;
    b.line_in    = l;
    return b;
  endfunction

  // random beat: mostly ticks, a start command now and then, byte extremes favored
  function automatic in_item_t random_beat(int cmd_pct);
    in_item_t b;
    b.action = ACT_TICK;
    if ($urandom_range(99) < cmd_pct) begin
      case ($urandom_range(2))
        0:       b.action = ACT_RESET;
        1:       b.action = ACT_WRITE;
        default: b.action = ACT_READ;
      endcase
    end
    case ($urandom_range(7))
      0:       b.write_data = 8'h00;
      1:       b.write_data = 8'hFF;
      default: b.write_data = 8'($urandom);
    endcase
    b.line_in = 1'($urandom_range(1));
    return b;
  endfunction

  // offer one beat, with a random gap first, and wait until it is taken
  task automatic send_beat(in_item_t b);
    if ($urandom_range(99) < snd_idle) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_chan.valid      <= 1'b1;
    in_chan.action     <= b.action;
    in_chan.write_data <= b.write_data;
    in_chan.line_in    <= b.line_in;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic run_random(int count, int cmd_pct);
    repeat (count) send_beat(random_beat(cmd_pct));
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // drain, then tick the sequencer until it sits idle so timings change cleanly
  task automatic quiesce();
    drain();
    while (seq_active) begin
      repeat (8) send_beat(beat(ACT_TICK, 8'($urandom), 1'($urandom_range(1))));
      drain();
    end
  endtask

  // write all tick registers back to back, we stays high across the burst
  task automatic load_timings(input logic [REG_W-1:0] v [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls plus a long hold-off at two points of the run
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left      <= 0;
      results_seen   <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) results_seen <= results_seen + 1;
      if (hold_left != 0) begin
        out_chan.ready <= 1'b0;
        hold_left      <= hold_left - 1;
      end else if (out_chan.valid && out_chan.ready &&
                   (results_seen == 300 || results_seen == 1200)) begin
        out_chan.ready <= 1'b0;
        hold_left      <= HOLD_CYCLES - 1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // watchdog: any accepted beat or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("one_wire_bus_master regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.action     = ACT_TICK;
    in_chan.write_data = '0;
    in_chan.line_in    = 1'b0;
    out_chan.ready     = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_RESET_LOW;
    cfg_data           = '0;
    snd_idle           = 34;
    rcv_idle           = 48;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default timings: one full reset/presence sequence of 930 ticks,
    // every command inside it must come back rejected
    send_beat(beat(ACT_RESET, 8'h00, 1'b1));
    run_random(929, 5);
    quiesce();

    // all registers zero: every phase collapses to a single tick
    timings = '{default: '0};
    load_timings(timings);

    // idle tick, then reset with a device answering and commands while busy
    send_beat(beat(ACT_TICK,  8'hFF, 1'b0));
    send_beat(beat(ACT_RESET, 8'h00, 1'b1));
    send_beat(beat(ACT_WRITE, 8'hFF, 1'b0));
    send_beat(beat(ACT_READ,  8'h00, 1'b1));
    // reset with nobody answering, then a rejected reset on the last tick
    send_beat(beat(ACT_RESET, 8'h00, 1'b1));
    send_beat(beat(ACT_TICK,  8'h00, 1'b1));
    send_beat(beat(ACT_RESET, 8'h00, 1'b0));
    // write of all zeros, a read command thrown in mid byte
    send_beat(beat(ACT_WRITE, 8'h00, 1'b1));
    for (int i = 1; i < 16; i++)
      send_beat(beat((i == 5) ? ACT_READ : ACT_TICK, 8'hFF, 1'b1));
    // read with a random line on every tick
    send_beat(beat(ACT_READ, 8'h00, 1'b1));
    repeat (23) send_beat(beat(ACT_TICK, 8'($urandom), 1'($urandom_range(1))));
    run_random(100, 10);
    quiesce();

    // minimum legal timings
    timings = '{default: REG_W'(1)};
    load_timings(timings);
    run_random(100, 10);
    quiesce();

    // short random timings, sender now idles more than the receiver
    snd_idle = 48;
    rcv_idle = 34;
    foreach (timings[i]) timings[i] = REG_W'($urandom_range(1, 6));
    load_timings(timings);
    run_random(100, 10);
    quiesce();

    foreach (timings[i]) timings[i] = REG_W'($urandom_range(1, 12));
    load_timings(timings);
    run_random(100, 12);
    quiesce();

    // long reset pulse with no idling on either side
    snd_idle = 0;
    rcv_idle = 0;
    timings[REG_RESET_LOW]      = REG_W'(40);
    timings[REG_PRESENCE_WAIT]  = REG_W'(2);
    timings[REG_RESET_RECOVERY] = REG_W'(1);
    timings[REG_SHORT]          = REG_W'(1);
    timings[REG_LONG]           = REG_W'(2);
    timings[REG_READ_LOW]       = REG_W'(1);
    timings[REG_READ_SAMPLE]    = REG_W'(1);
    timings[REG_READ_TAIL]      = REG_W'(3);
    load_timings(timings);
    send_beat(beat(ACT_RESET, 8'h00, 1'b0));
    run_random(80, 10);

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("one_wire_bus_master regression: pass");
    end else begin
      $display("one_wire_bus_master regression: fail");
    end
    $finish;
  end

endmodule
